@@ rtl/core/spo_pkg.sv @@
// Package for the spiral-order matrix reader.
// Holds sizes, codes, beat structs and small helpers shared by all modules.
// No dependencies.
package spo_pkg;

   // Matrix limits and element width.
   localparam int MAX_ROWS    = 16;
   localparam int MAX_COLUMNS = 16;
   localparam int DATA_WIDTH  = 32;

   // Index widths into the store; the store is row-major with MAX_COLUMNS per row.
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;

   // Dimension registers and element counters.
   localparam int DIM_WIDTH   = 5;
   localparam int COUNT_WIDTH = $clog2(STORE_DEPTH + 1);

   // Control port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLUMN_COUNT = 2'd1;

   // Request codes.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic                         req_type;
      logic signed [DATA_WIDTH-1:0] element_value;
   } req_beat_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] spiral_value;
      logic                         last_element;
      logic                         exhausted;
   } rsp_beat_type;

   // What the walker tells the datapath about the current beat.
   typedef struct packed {
      logic [ADDR_BITS-1:0] wr_addr;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 exhausted;
      logic                 last;
      logic                 in_range;
   } walk_view_type;

   // Clamp a dimension to 1..limit.
   function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] dim,
                                                      input logic [DIM_WIDTH-1:0] limit);
      logic [DIM_WIDTH-1:0] result;
      if (dim == '0) begin
         result = DIM_WIDTH'(1);
      end else if (dim > limit) begin
         result = limit;
      end else begin
         result = dim;
      end
      return result;
   endfunction

endpackage

@@ rtl/core/spiral_order_matrix_reader_unit.sv @@
// Spiral-order matrix reader: read beats pass a read stage, then a response register.
// One beat per cycle, set by the single registered read port, unless rsp_ready stalls.
// Write beats give no response and restart the spiral walk.
// Reset clears all control state and sets both dimensions to 1.
// Store contents are undefined after reset until written.
// Depends on spo_pkg, spo_walk and spo_store.
module spiral_order_matrix_reader_unit
   import spo_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_beat_type               req_beat,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_beat_type               rsp_beat,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DIM_WIDTH-1:0]       csr_data
);

   walk_view_type         view;
   logic                  req_fire, load_beat, read_beat, csr_write;
   logic [DATA_WIDTH-1:0] rd_data;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_exhausted_ff, s1_last_ff, s1_zero_ff;
   logic                  s1_move;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_beat_type          rsp_beat_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Accept a beat when the read stage is empty or moving on.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign load_beat = req_fire && req_beat.req_type == REQ_WRITE;
   assign read_beat = req_fire && req_beat.req_type == REQ_READ;

   spo_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .load_beat (load_beat),
      .read_beat (read_beat),
      .view      (view)
   );

   spo_store u_store (
      .clock   (clock),
      .wr_en   (load_beat),
      .wr_addr (view.wr_addr),
      .wr_data (req_beat.element_value),
      .rd_en   (read_beat),
      .rd_addr (view.rd_addr),
      .rd_data (rd_data)
   );

   // Read stage: flags travel beside the store's read data.
   assign s1_valid_in = read_beat || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (read_beat) begin
         s1_exhausted_ff <= view.exhausted;
         s1_last_ff      <= !view.exhausted && view.last;
         s1_zero_ff      <= view.exhausted || !view.in_range;
      end
   end

   // Response register.
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_beat_ff.spiral_value <= s1_zero_ff ? '0 : rd_data;
         rsp_beat_ff.last_element <= s1_last_ff;
         rsp_beat_ff.exhausted    <= s1_exhausted_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

@@ rtl/core/spo_store.sv @@
// Element store of the spiral-order matrix reader: one write port, one read port.
// Read data is registered. Depends on spo_pkg.
module spo_store
   import spo_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/spo_walk.sv @@
// Position tracking for the spiral-order matrix reader: dimension registers,
// row-major load pointer and the spiral walker. Depends on spo_pkg.
module spo_walk
   import spo_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DIM_WIDTH-1:0]       csr_data,
   input  logic                       load_beat,
   input  logic                       read_beat,
   output walk_view_type              view
);

   localparam logic [DIM_WIDTH-1:0] ROW_LIMIT = DIM_WIDTH'(MAX_ROWS);
   localparam logic [DIM_WIDTH-1:0] COL_LIMIT = DIM_WIDTH'(MAX_COLUMNS);

   logic [DIM_WIDTH-1:0]   row_count_ff, row_count_in;
   logic [DIM_WIDTH-1:0]   column_count_ff, column_count_in;
   logic [ROW_BITS-1:0]    load_row_ff, load_row_in;
   logic [COL_BITS-1:0]    load_col_ff, load_col_in;
   logic [DIM_WIDTH-1:0]   cur_row_ff, cur_row_in;
   logic [DIM_WIDTH-1:0]   cur_col_ff, cur_col_in;
   logic [DIM_WIDTH-1:0]   hsteps_ff, hsteps_in;
   logic [DIM_WIDTH-1:0]   vsteps_ff, vsteps_in;
   logic [DIM_WIDTH-1:0]   run_ff, run_in;
   logic                   horiz_ff, horiz_in;
   logic                   reverse_ff, reverse_in;
   logic [COUNT_WIDTH-1:0] emitted_ff, emitted_in;

   logic [DIM_WIDTH-1:0]   rows_eff, cols_eff;
   logic [DIM_WIDTH-1:0]   rows_next, cols_next;
   logic [COUNT_WIDTH-1:0] total;
   logic [COUNT_WIDTH-1:0] emitted_inc;
   logic [DIM_WIDTH-1:0]   steps;
   logic [DIM_WIDTH:0]     run_inc;
   logic                   dir_horiz, dir_reverse;
   logic                   exhausted;
   logic                   csr_hit;

   // Of the control writes, only one to one of the two dimension registers restarts anything.
   assign csr_hit = csr_write &&
                    (csr_index == CSR_ROW_COUNT || csr_index == CSR_COLUMN_COUNT);

   // Effective dimensions, now and after a pending register write.
   always_comb begin
      rows_eff  = clamp_dim(row_count_ff, ROW_LIMIT);
      cols_eff  = clamp_dim(column_count_ff, COL_LIMIT);
      rows_next = clamp_dim(row_count_in, ROW_LIMIT);
      cols_next = clamp_dim(column_count_in, COL_LIMIT);
      total     = COUNT_WIDTH'(rows_eff) * COUNT_WIDTH'(cols_eff);
   end

   // Dimension registers.
   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_write && csr_index == CSR_ROW_COUNT) begin
         row_count_in = csr_data;
      end
      if (csr_write && csr_index == CSR_COLUMN_COUNT) begin
         column_count_in = csr_data;
      end
   end

   // Row-major load pointer. It wraps to the top-left after the last element.
   always_comb begin
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      if (csr_hit) begin
         load_row_in = '0;
         load_col_in = '0;
      end else if (load_beat) begin
         if ((DIM_WIDTH'(load_col_ff) + DIM_WIDTH'(1)) == cols_eff) begin
            load_col_in = '0;
            if ((DIM_WIDTH'(load_row_ff) + DIM_WIDTH'(1)) == rows_eff) begin
               load_row_in = '0;
            end else begin
               load_row_in = load_row_ff + ROW_BITS'(1);
            end
         end else begin
            load_col_in = load_col_ff + COL_BITS'(1);
         end
      end
   end

   assign exhausted   = emitted_ff >= total;
   assign emitted_inc = emitted_ff + COUNT_WIDTH'(1);
   assign steps       = horiz_ff ? hsteps_ff : vsteps_ff;
   assign run_inc     = {1'b0, run_ff} + (DIM_WIDTH + 1)'(1);

   // Spiral walker: one step per read until all elements are emitted; a turn at the end of each run.
   always_comb begin
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      hsteps_in   = hsteps_ff;
      vsteps_in   = vsteps_ff;
      run_in      = run_ff;
      horiz_in    = horiz_ff;
      reverse_in  = reverse_ff;
      emitted_in  = emitted_ff;
      dir_horiz   = horiz_ff;
      dir_reverse = reverse_ff;
      if (csr_hit || load_beat) begin
         // Any write to a dimension register, and any load beat, restarts the traversal from the top-left corner.
         cur_row_in = '0;
         cur_col_in = '0;
         hsteps_in  = cols_next;
         vsteps_in  = rows_next - DIM_WIDTH'(1);
         run_in     = '0;
         horiz_in   = 1'b1;
         reverse_in = 1'b0;
         emitted_in = '0;
      end else if (read_beat && !exhausted) begin
         emitted_in = emitted_inc;
         if (run_inc < {1'b0, steps}) begin
            run_in = run_inc[DIM_WIDTH-1:0];
         end else begin
            run_in = '0;
            if (horiz_ff) begin
               if (hsteps_ff != '0) begin
                  hsteps_in = hsteps_ff - DIM_WIDTH'(1);
               end
            end else begin
               if (vsteps_ff != '0) begin
                  vsteps_in = vsteps_ff - DIM_WIDTH'(1);
               end
            end
            dir_horiz   = !horiz_ff;
            dir_reverse = dir_horiz ? !reverse_ff : reverse_ff;
            horiz_in    = dir_horiz;
            reverse_in  = dir_reverse;
         end
         if (dir_horiz) begin
            cur_col_in = dir_reverse ? cur_col_ff - DIM_WIDTH'(1) : cur_col_ff + DIM_WIDTH'(1);
         end else begin
            cur_row_in = dir_reverse ? cur_row_ff - DIM_WIDTH'(1) : cur_row_ff + DIM_WIDTH'(1);
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= DIM_WIDTH'(1);
         column_count_ff <= DIM_WIDTH'(1);
         load_row_ff     <= '0;
         load_col_ff     <= '0;
         cur_row_ff      <= '0;
         cur_col_ff      <= '0;
         hsteps_ff       <= DIM_WIDTH'(1);
         vsteps_ff       <= '0;
         run_ff          <= '0;
         horiz_ff        <= 1'b1;
         reverse_ff      <= 1'b0;
         emitted_ff      <= '0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         load_row_ff     <= load_row_in;
         load_col_ff     <= load_col_in;
         cur_row_ff      <= cur_row_in;
         cur_col_ff      <= cur_col_in;
         hsteps_ff       <= hsteps_in;
         vsteps_ff       <= vsteps_in;
         run_ff          <= run_in;
         horiz_ff        <= horiz_in;
         reverse_ff      <= reverse_in;
         emitted_ff      <= emitted_in;
      end
   end

   // Store addresses are row * MAX_COLUMNS + column.
   always_comb begin
      view.wr_addr   = {load_row_ff, load_col_ff};
      view.rd_addr   = {cur_row_ff[ROW_BITS-1:0], cur_col_ff[COL_BITS-1:0]};
      view.exhausted = exhausted;
      view.last      = emitted_inc == total;
      view.in_range  = (cur_row_ff < rows_eff) && (cur_col_ff < cols_eff);
   end

endmodule

@@ rtl/core/spo_check.sv @@
// Port-level checks for the spiral-order matrix reader, bound to the top level.
// Depends on spo_pkg and spiral_order_matrix_reader_unit.
module spo_check
   import spo_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_beat_type rsp_beat
);

   // A stalled response holds its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
      else $error("response beat changed while stalled");

   // A beat is never both the final element and an exhausted read.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_beat.last_element && rsp_beat.exhausted))
      else $error("last and exhausted both set");

   // An exhausted read carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.exhausted |-> rsp_beat.spiral_value == '0)
      else $error("exhausted read with nonzero value");

   // No response is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind spiral_order_matrix_reader_unit spo_check u_check (.*);
